FILE: hw/rtl/ipvfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipvfd_pkg
// Types and constants shared by the IPv4 forwarding decision block.
// ----------------------------------------------------------------------------
package ipvfd_pkg;

   localparam logic [1:0] FUNC_CLEAR    = 2'd0;
   localparam logic [1:0] FUNC_APPEND   = 2'd1;
   localparam logic [1:0] FUNC_CLASSIFY = 2'd2;

   localparam logic [2:0] ACT_DONE          = 3'd0;
   localparam logic [2:0] ACT_DROP          = 3'd1;
   localparam logic [2:0] ACT_FORWARD       = 3'd2;
   localparam logic [2:0] ACT_ECHO          = 3'd3;
   localparam logic [2:0] ACT_TIME_EXCEEDED = 3'd4;
   localparam logic [2:0] ACT_NET_UNREACH   = 3'd5;
   localparam logic [2:0] ACT_PORT_UNREACH  = 3'd6;
   localparam logic [2:0] ACT_ARP           = 3'd7;

   localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
   localparam logic [15:0] ETH_TYPE_ARP   = 16'h0806;
   localparam logic [15:0] MIN_ETH_LEN    = 16'd14;
   localparam logic [15:0] MIN_IP_LEN     = 16'd34;
   localparam logic [15:0] MIN_ICMP_LEN   = 16'd38;
   localparam logic [3:0]  IP_VERSION_4   = 4'd4;
   localparam logic [7:0]  PROTO_ICMP     = 8'd1;
   localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;

   localparam logic [2:0] REG_IFACE0_IP   = 3'd0;
   localparam logic [2:0] REG_IFACE1_IP   = 3'd1;
   localparam logic [2:0] REG_IFACE2_IP   = 3'd2;
   localparam logic [2:0] REG_IFACE3_IP   = 3'd3;
   localparam logic [2:0] REG_IFACE_COUNT = 3'd4;

   localparam int IFACES = 4;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] addr_a;
      logic [31:0] addr_b;
      logic [31:0] gateway;
      logic [1:0]  route_port;
      logic [15:0] frame_len;
      logic [15:0] frame_type;
      logic [3:0]  ip_version;
      logic        checksum_ok;
      logic [7:0]  ttl;
      logic [7:0]  protocol;
      logic [7:0]  icmp_kind;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] next_hop;
      logic [1:0]  out_port;
      logic [7:0]  new_ttl;
      logic [31:0] reply_src_ip;
      logic        table_full;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] mask;
      logic [31:0] gw;
      logic [1:0]  port;
   } route_entry_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic walk_step;
      logic retry;
      logic finish_hit;
      logic finish_drop;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic direct;
      logic walk_done;
      logic found;
      logic retry_ok;
      logic out_free;
   } dp_status_type;

endpackage

FILE: hw/rtl/ipvfd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipvfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipvfd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/ipvfd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipvfd_ctrl
// Sequencer: take a request, evaluate it, walk the route table if needed, emit result.
// ----------------------------------------------------------------------------
module ipvfd_ctrl import ipvfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.direct ? S_OUT : S_WALK;
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_done) begin
               if (status.found) begin
                  cmd.finish_hit = 1'b1;
                  state_in       = S_OUT;
               end else if (status.retry_ok) begin
                  cmd.retry = 1'b1;
               end else begin
                  cmd.finish_drop = 1'b1;
                  state_in        = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (cmd.capture |=> state_ff == S_EVAL))
      else $error("accepted request did not move to evaluation");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit |-> !(cmd.finish_hit || cmd.finish_drop || cmd.eval)))
      else $error("emit overlaps with result update");

   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_WALK && status.walk_done && !status.found && !status.retry_ok)
       |=> state_ff == S_OUT))
      else $error("failed walk did not end in drop");

endmodule

FILE: hw/rtl/ipvfd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipvfd_dp
// Datapath: request hold, header checks, route table walk, result registers.
// ----------------------------------------------------------------------------
module ipvfd_dp import ipvfd_pkg::*; #(
   parameter int ROUTES = 16,
   parameter int PORTS  = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   input  req_item_type           req_item,
   input  logic [IFACES-1:0][31:0] iface_ip,
   input  logic [2:0]             iface_count,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output rsp_item_type           rsp_item
);

   localparam int AW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
   localparam int CW = $clog2(ROUTES + 1);
   localparam int RW = $bits(route_entry_type);

   req_item_type    item_ff, item_in;
   rsp_item_type    res_ff, res_in;
   rsp_item_type    out_ff, out_in;
   logic            out_vld_ff, out_vld_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            cmp_vld_ff, cmp_vld_in;
   logic            found_ff, found_in;
   logic [31:0]     best_ff, best_in;
   logic [31:0]     hit_gw_ff, hit_gw_in;
   logic [1:0]      hit_port_ff, hit_port_in;
   logic [31:0]     key_ff, key_in;
   logic [2:0]      walk_act_ff, walk_act_in;

   route_entry_type wr_entry;
   route_entry_type rd_entry;
   logic [RW-1:0]   rd_raw;
   logic            wr_en;
   logic            rd_en;
   logic            full;
   logic [2:0]      active;
   logic            is_router;
   logic [7:0]      nt;
   logic            pre_direct;
   logic [2:0]      pre_act;
   logic [2:0]      pre_walk_act;
   logic [31:0]     pre_key;
   logic            hit;

   assign full   = (count_ff >= CW'(ROUTES));
   assign active = (iface_count > 3'(PORTS)) ? 3'(PORTS) : iface_count;
   assign nt     = item_ff.ttl - 8'd1;

   always_comb begin
      is_router = 1'b0;
      for (int i = 0; i < IFACES; i++) begin
         if ((3'(i) < active) && (iface_ip[i] == item_ff.addr_a)) begin
            is_router = 1'b1;
         end
      end
   end

   always_comb begin
      pre_direct   = 1'b1;
      pre_act      = ACT_DONE;
      pre_walk_act = ACT_FORWARD;
      pre_key      = item_ff.addr_b;
      if (item_ff.func == FUNC_CLASSIFY) begin
         if (item_ff.frame_len < MIN_ETH_LEN) begin
            pre_act = ACT_DROP;
         end else if (item_ff.frame_type == ETH_TYPE_ARP) begin
            pre_act = ACT_ARP;
         end else if (item_ff.frame_type != ETH_TYPE_IPV4) begin
            pre_act = ACT_DROP;
         end else if (item_ff.frame_len < MIN_IP_LEN || !item_ff.checksum_ok ||
                      item_ff.ip_version != IP_VERSION_4) begin
            pre_act = ACT_DROP;
         end else if (!is_router) begin
            pre_direct = 1'b0;
            if (nt == 8'd0) begin
               pre_walk_act = ACT_TIME_EXCEEDED;
            end else begin
               pre_walk_act = ACT_FORWARD;
               pre_key      = item_ff.addr_a;
            end
         end else if (item_ff.protocol == PROTO_ICMP) begin
            if (item_ff.frame_len < MIN_ICMP_LEN || item_ff.icmp_kind != ICMP_ECHO_REQ) begin
               pre_act = ACT_DROP;
            end else begin
               pre_direct   = 1'b0;
               pre_walk_act = ACT_ECHO;
            end
         end else begin
            pre_direct   = 1'b0;
            pre_walk_act = ACT_PORT_UNREACH;
         end
      end
   end

   assign wr_en          = cmd.eval && (item_ff.func == FUNC_APPEND) && !full;
   assign wr_entry.dest  = item_ff.addr_a;
   assign wr_entry.mask  = item_ff.addr_b;
   assign wr_entry.gw    = item_ff.gateway;
   assign wr_entry.port  = item_ff.route_port;
   assign rd_en          = cmd.walk_step && (idx_ff < count_ff);
   assign rd_entry       = route_entry_type'(rd_raw);

   ipvfd_ram #(
      .WIDTH (RW),
      .DEPTH (ROUTES)
   ) u_route_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_raw)
   );

   assign hit = cmp_vld_ff &&
                ((key_ff & rd_entry.mask) == (rd_entry.dest & rd_entry.mask)) &&
                (rd_entry.mask >= best_ff);

   always_comb begin
      item_in     = cmd.capture ? req_item : item_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      cmp_vld_in  = 1'b0;
      found_in    = found_ff;
      best_in     = best_ff;
      hit_gw_in   = hit_gw_ff;
      hit_port_in = hit_port_ff;
      key_in      = key_ff;
      walk_act_in = walk_act_ff;
      res_in      = res_ff;

      if (cmd.eval && item_ff.func == FUNC_CLEAR) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CW'(1);
      end

      if (cmd.eval || cmd.retry) begin
         idx_in   = '0;
         found_in = 1'b0;
         best_in  = '0;
         key_in   = cmd.eval ? pre_key : item_ff.addr_b;
         walk_act_in = cmd.eval ? pre_walk_act : ACT_NET_UNREACH;
      end else if (cmd.walk_step) begin
         cmp_vld_in = rd_en;
         if (rd_en) begin
            idx_in = idx_ff + CW'(1);
         end
         if (hit) begin
            found_in    = 1'b1;
            best_in     = rd_entry.mask;
            hit_gw_in   = rd_entry.gw;
            hit_port_in = rd_entry.port;
         end
      end

      if (cmd.eval) begin
         res_in            = '0;
         res_in.action     = pre_act;
         res_in.table_full = (item_ff.func == FUNC_APPEND) && full;
      end else if (cmd.finish_drop) begin
         res_in        = '0;
         res_in.action = ACT_DROP;
      end else if (cmd.finish_hit) begin
         res_in          = '0;
         res_in.action   = walk_act_ff;
         res_in.next_hop = hit_gw_ff;
         res_in.out_port = hit_port_ff;
         if (walk_act_ff inside {ACT_FORWARD, ACT_TIME_EXCEEDED, ACT_NET_UNREACH}) begin
            res_in.new_ttl = nt;
         end
         if (walk_act_ff inside {ACT_TIME_EXCEEDED, ACT_NET_UNREACH}) begin
            res_in.reply_src_ip = ({1'b0, hit_port_ff} < active) ? iface_ip[hit_port_ff] : '0;
         end else if (walk_act_ff inside {ACT_ECHO, ACT_PORT_UNREACH}) begin
            res_in.reply_src_ip = item_ff.addr_a;
         end
      end
   end

   always_comb begin
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_tready;
      if (cmd.emit) begin
         out_in     = res_ff;
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         out_vld_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
         idx_ff     <= '0;
         found_ff   <= 1'b0;
      end else begin
         count_ff   <= count_in;
         out_vld_ff <= out_vld_in;
         cmp_vld_ff <= cmp_vld_in;
         idx_ff     <= idx_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
      best_ff     <= best_in;
      hit_gw_ff   <= hit_gw_in;
      hit_port_ff <= hit_port_in;
      key_ff      <= key_in;
      walk_act_ff <= walk_act_in;
   end

   assign status.direct    = pre_direct;
   assign status.walk_done = (idx_ff >= count_ff) && !cmp_vld_ff;
   assign status.found     = found_ff;
   assign status.retry_ok  = (walk_act_ff == ACT_FORWARD);
   assign status.out_free  = !out_vld_ff || rsp_tready;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_item   = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CW'(ROUTES)))
      else $error("route count beyond table depth");

   assert property (@(posedge clock) disable iff (reset)
      ((out_vld_ff && (out_ff.action == ACT_DROP || out_ff.action == ACT_ARP ||
                       out_ff.action == ACT_DONE))
       |-> (out_ff.next_hop == '0 && out_ff.new_ttl == '0 && out_ff.reply_src_ip == '0)))
      else $error("non-routed result carries route fields");

   assert property (@(posedge clock) disable iff (reset)
      ((out_vld_ff && out_ff.table_full) |-> out_ff.action == ACT_DONE))
      else $error("table full flag on a non-table result");

   assert property (@(posedge clock) disable iff (reset)
      ((out_vld_ff && out_ff.action == ACT_FORWARD) |-> out_ff.new_ttl != 8'd0))
      else $error("forwarded packet with expired ttl");

endmodule

FILE: hw/rtl/ipv4_forwarding_decision.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision
// Router forwarding decision with a longest-prefix-match route table.
// ----------------------------------------------------------------------------
// Table ops and header-only decisions go from accept through evaluation to rsp_tvalid.
// Routed requests walk the route table one entry per cycle over the N stored routes;
// a forward miss walks the table twice, the second time back toward the source.
// One request in flight: the next is accepted once the result loads into the output
// register, and rsp stalls delay that load.
// Reset clears the route count, interface registers and control; entries stay.
module ipv4_forwarding_decision import ipvfd_pkg::*; #(
   parameter int ROUTES = 16,
   parameter int PORTS  = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // addr_a, addr_b, gateway, route_port, frame_len, frame_type, ip_version,
   // checksum_ok, ttl, protocol, icmp_kind, zero pad
   input  logic [159:0] req_tdata,
   // func
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // next_hop, out_port, new_ttl, reply_src_ip, table_full, zero pad
   output logic [79:0]  rsp_tdata,
   // action
   output logic [2:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [IFACES-1:0][31:0] iface_ip_ff, iface_ip_in;
   logic [2:0]              iface_count_ff, iface_count_in;
   logic                    csr_wr;
   logic [2:0]              csr_idx;
   req_item_type            req_item;
   rsp_item_type            rsp_item;
   ctrl_cmd_type            cmd;
   dp_status_type           status;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      iface_ip_in    = iface_ip_ff;
      iface_count_in = iface_count_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_IFACE0_IP:   iface_ip_in[0] = csr_pwdata;
            REG_IFACE1_IP:   iface_ip_in[1] = csr_pwdata;
            REG_IFACE2_IP:   iface_ip_in[2] = csr_pwdata;
            REG_IFACE3_IP:   iface_ip_in[3] = csr_pwdata;
            REG_IFACE_COUNT: iface_count_in = csr_pwdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_IFACE0_IP:   csr_prdata = iface_ip_ff[0];
         REG_IFACE1_IP:   csr_prdata = iface_ip_ff[1];
         REG_IFACE2_IP:   csr_prdata = iface_ip_ff[2];
         REG_IFACE3_IP:   csr_prdata = iface_ip_ff[3];
         REG_IFACE_COUNT: csr_prdata = {29'd0, iface_count_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iface_ip_ff    <= '0;
         iface_count_ff <= '0;
      end else begin
         iface_ip_ff    <= iface_ip_in;
         iface_count_ff <= iface_count_in;
      end
   end

   assign req_item.func        = req_tuser;
   assign req_item.addr_a      = req_tdata[31:0];
   assign req_item.addr_b      = req_tdata[63:32];
   assign req_item.gateway     = req_tdata[95:64];
   assign req_item.route_port  = req_tdata[97:96];
   assign req_item.frame_len   = req_tdata[113:98];
   assign req_item.frame_type  = req_tdata[129:114];
   assign req_item.ip_version  = req_tdata[133:130];
   assign req_item.checksum_ok = req_tdata[134];
   assign req_item.ttl         = req_tdata[142:135];
   assign req_item.protocol    = req_tdata[150:143];
   assign req_item.icmp_kind   = req_tdata[158:151];

   assign rsp_tuser = rsp_item.action;
   assign rsp_tdata = {5'd0, rsp_item.table_full, rsp_item.reply_src_ip,
                       rsp_item.new_ttl, rsp_item.out_port, rsp_item.next_hop};

   ipvfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ipvfd_dp #(
      .ROUTES (ROUTES),
      .PORTS  (PORTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_item    (req_item),
      .iface_ip    (iface_ip_ff),
      .iface_count (iface_count_ff),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_item    (rsp_item)
   );

endmodule

FILE: tb/sv/ipv4_forwarding_decision_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision_tb
// Self-checking bench for the IPv4 forwarding decision block. A directed
// sequence walks the header checks, the route table and the reply paths.
// Random traffic follows under several interface settings: mostly well-formed
// headers aimed at router and route addresses, table refills that overrun
// the table, and malformed frames. Both stream sides idle and stall at
// random, and one long result back-pressure fills the block. Each decision
// is checked field by field against a local model of the forwarding logic.
// ----------------------------------------------------------------------------
module ipv4_forwarding_decision_tb import ipvfd_pkg::*; ();

   localparam int         ROUTE_SLOTS = 16;
   localparam int         HOLD_CYCLES = 300;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   class forwarding_board;
      logic [31:0]    route_dest [ROUTE_SLOTS];
      logic [31:0]    route_mask [ROUTE_SLOTS];
      logic [31:0]    route_gw   [ROUTE_SLOTS];
      logic [1:0]     route_out  [ROUTE_SLOTS];
      int             route_count;
      logic [31:0]    iface_ip [4];
      logic [2:0]     iface_count;
      rsp_item_type   decisions_due [$];
      int             errors;
      int             requests;
      int             act_seen [8];
      int             full_seen;

      function new();
         foreach (route_dest[i]) begin
            route_dest[i] = '0;
            route_mask[i] = '0;
            route_gw[i]   = '0;
            route_out[i]  = '0;
         end
         foreach (iface_ip[i]) iface_ip[i] = '0;
         foreach (act_seen[i]) act_seen[i] = 0;
         route_count = 0;
         iface_count = '0;
         errors      = 0;
         requests    = 0;
         full_seen   = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_IFACE0_IP, REG_IFACE1_IP, REG_IFACE2_IP, REG_IFACE3_IP:
               iface_ip[idx[1:0]] = value;
            REG_IFACE_COUNT: iface_count = value[2:0];
            default: ;
         endcase
      endfunction

      function int active_ports();
         return (iface_count > IFACES) ? IFACES : int'(iface_count);
      endfunction

      function bit is_local(logic [31:0] a);
         for (int i = 0; i < active_ports(); i++)
            if (iface_ip[i] == a) return 1'b1;
         return 1'b0;
      endfunction

      // longest mask wins; a later entry wins a tie
      function bit find_route(input logic [31:0] a, output int hit);
         logic [31:0] best;
         bit          found;
         best  = '0;
         found = 1'b0;
         hit   = 0;
         for (int i = 0; i < route_count; i++) begin
            if (((a ^ route_dest[i]) & route_mask[i]) == '0 && route_mask[i] >= best) begin
               best  = route_mask[i];
               hit   = i;
               found = 1'b1;
            end
         end
         return found;
      endfunction

      function void route_back(logic [31:0] src, logic [2:0] act, inout rsp_item_type r);
         int hit;
         if (find_route(src, hit)) begin
            r.action   = act;
            r.next_hop = route_gw[hit];
            r.out_port = route_out[hit];
         end else begin
            r.action = ACT_DROP;
         end
      endfunction

      function rsp_item_type decide(req_item_type q);
         rsp_item_type r;
         logic [7:0]   nt;
         int           hit;
         r = '0;
         r.action = ACT_DONE;
         case (q.func)
            FUNC_CLEAR: route_count = 0;
            FUNC_APPEND: begin
               if (route_count < ROUTE_SLOTS) begin
                  route_dest[route_count] = q.addr_a;
                  route_mask[route_count] = q.addr_b;
                  route_gw[route_count]   = q.gateway;
                  route_out[route_count]  = q.route_port;
                  route_count++;
               end else begin
                  r.table_full = 1'b1;
               end
            end
            FUNC_CLASSIFY: begin
               if (q.frame_len < MIN_ETH_LEN) begin
                  r.action = ACT_DROP;
               end else if (q.frame_type == ETH_TYPE_ARP) begin
                  r.action = ACT_ARP;
               end else if (q.frame_type != ETH_TYPE_IPV4 || q.frame_len < MIN_IP_LEN ||
                            !q.checksum_ok || q.ip_version != IP_VERSION_4) begin
                  r.action = ACT_DROP;
               end else if (!is_local(q.addr_a)) begin
                  nt = q.ttl - 8'd1;
                  if (nt == 8'd0) begin
                     route_back(q.addr_b, ACT_TIME_EXCEEDED, r);
                  end else if (find_route(q.addr_a, hit)) begin
                     r.action   = ACT_FORWARD;
                     r.next_hop = route_gw[hit];
                     r.out_port = route_out[hit];
                  end else begin
                     route_back(q.addr_b, ACT_NET_UNREACH, r);
                  end
                  if (r.action != ACT_DROP) r.new_ttl = nt;
                  if (r.action inside {ACT_TIME_EXCEEDED, ACT_NET_UNREACH})
                     r.reply_src_ip = (r.out_port < active_ports()) ? iface_ip[r.out_port] : '0;
               end else if (q.protocol == PROTO_ICMP) begin
                  if (q.frame_len < MIN_ICMP_LEN || q.icmp_kind != ICMP_ECHO_REQ)
                     r.action = ACT_DROP;
                  else
                     route_back(q.addr_b, ACT_ECHO, r);
                  if (r.action == ACT_ECHO) r.reply_src_ip = q.addr_a;
               end else begin
                  route_back(q.addr_b, ACT_PORT_UNREACH, r);
                  if (r.action == ACT_PORT_UNREACH) r.reply_src_ip = q.addr_a;
               end
               if (r.action inside {ACT_DROP, ACT_ARP}) begin
                  r.next_hop     = '0;
                  r.out_port     = '0;
                  r.new_ttl      = '0;
                  r.reply_src_ip = '0;
               end
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_request(req_item_type q);
         decisions_due.push_back(decide(q));
         requests++;
      endfunction

      function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void check_decision(rsp_item_type got);
         rsp_item_type want;
         bit           ok;
         if (decisions_due.size() == 0) begin
            $display("%0t: decision with no request pending: expected none, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = decisions_due.pop_front();
         ok = field_ok("action", 32'(want.action), 32'(got.action));
         ok &= field_ok("next_hop", want.next_hop, got.next_hop);
         ok &= field_ok("out_port", 32'(want.out_port), 32'(got.out_port));
         ok &= field_ok("new_ttl", 32'(want.new_ttl), 32'(got.new_ttl));
         ok &= field_ok("reply_src_ip", want.reply_src_ip, got.reply_src_ip);
         ok &= field_ok("table_full", 32'(want.table_full), 32'(got.table_full));
         if (!ok) errors++;
         act_seen[want.action]++;
         if (want.table_full) full_seen++;
      endfunction

      function int pending();
         return decisions_due.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [159:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [4:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   forwarding_board board;
   rsp_item_type    seen;
   int              tx_idle_pct;
   int              rx_stall_pct;
   int              hold_requests;
   int              hold_seen;
   int              hold_left;
   int              refill_left;
   int              settings_used;

   ipv4_forwarding_decision dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   initial begin
      #4_000_000;
      $display("%0t: timeout with %0d decisions outstanding", $time, board.pending());
      $display("Mismatches found");
      $finish;
   end

   // count the long back-pressure stretch
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_left <= HOLD_CYCLES;
         hold_seen <= hold_requests;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.action       = rsp_tuser;
         seen.next_hop     = rsp_tdata[31:0];
         seen.out_port     = rsp_tdata[33:32];
         seen.new_ttl      = rsp_tdata[41:34];
         seen.reply_src_ip = rsp_tdata[73:42];
         seen.table_full   = rsp_tdata[74];
         board.check_decision(seen);
      end
   end

   function automatic logic [31:0] prefix_mask(int len);
      return 32'(64'hffff_ffff_0000_0000 >> len);
   endfunction

   // favor router and route addresses so lookups hit
   function automatic logic [31:0] pick_addr();
      int          i;
      logic [31:0] noise;
      noise = $urandom;
      case ($urandom_range(0, 7))
         0, 1: return board.iface_ip[$urandom_range(0, 3)];
         2, 3, 4: begin
            if (board.route_count > 0) begin
               i = $urandom_range(0, board.route_count - 1);
               return (board.route_dest[i] & board.route_mask[i]) | (noise & ~board.route_mask[i]);
            end
         end
         5: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
         default: ;
      endcase
      return noise;
   endfunction

   function automatic req_item_type route(logic [31:0] dest, logic [31:0] mask,
                                          logic [31:0] gw, logic [1:0] port);
      req_item_type it;
      it = '0;
      it.func       = FUNC_APPEND;
      it.addr_a     = dest;
      it.addr_b     = mask;
      it.gateway    = gw;
      it.route_port = port;
      return it;
   endfunction

   function automatic req_item_type packet(logic [31:0] dst, logic [31:0] src,
                                           logic [15:0] len, logic [15:0] etype,
                                           logic [3:0] ver, logic ck, logic [7:0] ttl,
                                           logic [7:0] proto, logic [7:0] itype);
      req_item_type it;
      it = '0;
      it.func        = FUNC_CLASSIFY;
      it.addr_a      = dst;
      it.addr_b      = src;
      it.frame_len   = len;
      it.frame_type  = etype;
      it.ip_version  = ver;
      it.checksum_ok = ck;
      it.ttl         = ttl;
      it.protocol    = proto;
      it.icmp_kind   = itype;
      return it;
   endfunction

   function automatic req_item_type next_request();
      req_item_type it;
      int           roll;
      it.addr_a      = $urandom;
      it.addr_b      = $urandom;
      it.gateway     = $urandom;
      it.route_port  = 2'($urandom);
      it.frame_len   = 16'($urandom);
      it.frame_type  = 16'($urandom);
      it.ip_version  = 4'($urandom);
      it.checksum_ok = 1'($urandom);
      it.ttl         = 8'($urandom);
      it.protocol    = 8'($urandom);
      it.icmp_kind   = 8'($urandom);
      roll = $urandom_range(0, 99);
      if (refill_left > 0) begin
         refill_left--;
         roll = 10;
      end
      if (roll < 3) begin
         it.func     = FUNC_CLEAR;
         refill_left = $urandom_range(0, 18);
      end else if (roll < 20) begin
         it.func = FUNC_APPEND;
         if ($urandom_range(0, 4) != 0) it.addr_b = prefix_mask($urandom_range(0, 32));
      end else if (roll < 22) begin
         it.func = FUNC_UNUSED;
      end else if (roll < 80) begin
         it.func        = FUNC_CLASSIFY;
         it.addr_a      = pick_addr();
         it.addr_b      = pick_addr();
         it.frame_len   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(34, 37)) :
                                                        16'($urandom_range(38, 1518));
         it.frame_type  = ETH_TYPE_IPV4;
         it.ip_version  = IP_VERSION_4;
         it.checksum_ok = 1'b1;
         if ($urandom_range(0, 3) == 0) it.ttl = 8'($urandom_range(0, 2));
         if ($urandom_range(0, 1) != 0) it.protocol = PROTO_ICMP;
         if ($urandom_range(0, 4) != 0) it.icmp_kind = ICMP_ECHO_REQ;
      end else begin
         it.func   = FUNC_CLASSIFY;
         it.addr_a = pick_addr();
         it.addr_b = pick_addr();
         if ($urandom_range(0, 1) != 0) it.frame_len = 16'($urandom_range(0, 40));
         case ($urandom_range(0, 2))
            0: it.frame_type = ETH_TYPE_IPV4;
            1: it.frame_type = ETH_TYPE_ARP;
            default: ;
         endcase
         if ($urandom_range(0, 1) != 0) it.ip_version = IP_VERSION_4;
      end
      return it;
   endfunction

   task automatic send_request(input req_item_type it);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.func;
      req_tdata  <= {1'b0, it.icmp_kind, it.protocol, it.ttl, it.checksum_ok, it.ip_version,
                     it.frame_type, it.frame_len, it.route_port, it.gateway, it.addr_b,
                     it.addr_a};
      do @(posedge clock); while (!req_tready);
      board.note_request(it);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [31:0] ip0, input logic [31:0] ip1,
                            input logic [31:0] ip2, input logic [31:0] ip3,
                            input logic [2:0] count);
      write_register(REG_IFACE0_IP, ip0);
      write_register(REG_IFACE1_IP, ip1);
      write_register(REG_IFACE2_IP, ip2);
      write_register(REG_IFACE3_IP, ip3);
      write_register(REG_IFACE_COUNT, 32'(count));
      settings_used++;
   endtask

   function automatic logic [31:0] pick_iface_ip();
      case ($urandom_range(0, 3))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [2:0]   counts [8];
      req_item_type it;
      counts = '{3'd0, 3'd7, 3'd1, 3'd4, 3'd2, 3'd5, 3'd3, 3'd6};
      board         = new();
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      tx_idle_pct   = 0;
      rx_stall_pct  = 0;
      hold_requests = 0;
      refill_left   = 0;
      settings_used = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      configure(32'h0a00_0001, 32'hc0a8_0101, 32'hffff_ffff, 32'h0000_0000, 3'd4);
      send_request(packet(32'h0808_0808, 32'h0102_0304, 16'd64, ETH_TYPE_IPV4,
                          IP_VERSION_4, 1'b1, 8'd64, 8'd17, 8'd0));
      it      = '1;
      it.func = FUNC_UNUSED;
      send_request(it);
      send_request(route(32'h0000_0000, 32'h0000_0000, 32'h0a00_00fe, 2'd0));
      send_request(route(32'h0a00_0000, 32'hff00_0000, 32'h0a00_00fd, 2'd1));
      send_request(route(32'h0a01_0000, 32'hffff_0000, 32'h0a01_00fe, 2'd2));
      send_request(route(32'h0a01_0000, 32'hffff_0000, 32'h0a01_00fd, 2'd3));
      send_request(route(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 2'd3));
      send_request(packet(32'h0a01_0203, 32'h0a05_0505, 16'd1518, ETH_TYPE_IPV4,
                          IP_VERSION_4, 1'b1, 8'd64, 8'd6, 8'd0));
      send_request(packet(32'h0a01_0203, 32'h0a05_0505, 16'd34, ETH_TYPE_IPV4,
                          IP_VERSION_4, 1'b1, 8'd0, 8'd6, 8'd0));
      send_request(packet(32'h0a01_0203, 32'h0a05_0505, 16'd60, ETH_TYPE_IPV4,
                          IP_VERSION_4, 1'b1, 8'd1, 8'd6, 8'd0));
      send_request(packet(32'h0808_0808, 32'h0a05_0505, 16'd60, ETH_TYPE_IPV4,
                          IP_VERSION_4, 1'b1, 8'd64, 8'd17, 8'd0));
      send_request(packet(32'h0a01_0203, 32'h0a05_0505, 16'd13, ETH_TYPE_IPV4,
                          IP_VERSION_4, 1'b1, 8'd64, 8'd6, 8'd0));
      send_request(packet(32'h0a01_0203, 32'h0a05_0505, 16'd0, ETH_TYPE_ARP,
                          IP_VERSION_4, 1'b1, 8'd64, 8'd6, 8'd0));
      send_request(packet(32'h0a01_0203, 32'h0a05_0505, 16'd14, ETH_TYPE_ARP,
                          4'd0, 1'b0, 8'd64, 8'd6, 8'd0));
      send_request(packet(32'h0a01_0203, 32'h0a05_0505, 16'd64, 16'hffff,
                          IP_VERSION_4, 1'b1, 8'd64, 8'd6, 8'd0));
      send_request(packet(32'h0a01_0203, 32'h0a05_0505, 16'd33, ETH_TYPE_IPV4,
                          IP_VERSION_4, 1'b1, 8'd64, 8'd6, 8'd0));
      send_request(packet(32'h0a01_0203, 32'h0a05_0505, 16'd64, ETH_TYPE_IPV4,
                          IP_VERSION_4, 1'b0, 8'd64, 8'd6, 8'd0));
      send_request(packet(32'h0a01_0203, 32'h0a05_0505, 16'd64, ETH_TYPE_IPV4,
                          4'd15, 1'b1, 8'd64, 8'd6, 8'd0));
      send_request(packet(32'hc0a8_0101, 32'h0a05_0505, 16'd38, ETH_TYPE_IPV4,
                          IP_VERSION_4, 1'b1, 8'd64, PROTO_ICMP, ICMP_ECHO_REQ));
      send_request(packet(32'hc0a8_0101, 32'h0a05_0505, 16'd37, ETH_TYPE_IPV4,
                          IP_VERSION_4, 1'b1, 8'd64, PROTO_ICMP, ICMP_ECHO_REQ));
      send_request(packet(32'hc0a8_0101, 32'h0a05_0505, 16'd98, ETH_TYPE_IPV4,
                          IP_VERSION_4, 1'b1, 8'd64, PROTO_ICMP, 8'd0));
      send_request(packet(32'hffff_ffff, 32'h0a05_0505, 16'd60, ETH_TYPE_IPV4,
                          IP_VERSION_4, 1'b1, 8'd1, 8'd6, 8'd0));
      send_request(packet(32'h0000_0000, 32'hffff_ffff, 16'd60, ETH_TYPE_IPV4,
                          IP_VERSION_4, 1'b1, 8'd255, 8'd255, 8'd255));
      send_request(packet(32'h1234_5678, 32'hffff_ffff, 16'hffff, ETH_TYPE_IPV4,
                          IP_VERSION_4, 1'b1, 8'd255, 8'd255, 8'd255));
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         configure(pick_iface_ip(), pick_iface_ip(), pick_iface_ip(), pick_iface_ip(),
                   counts[phase]);
         case (phase % 4)
            0: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 0;
            end
            1: begin
               tx_idle_pct  = 48;
               rx_stall_pct = 0;
            end
            2: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 48;
            end
            default: begin
               tx_idle_pct  = 19;
               rx_stall_pct = 19;
            end
         endcase
         if (phase == 4) hold_requests++;
         repeat (160) send_request(next_request());
         drain();
      end

      repeat (40) @(posedge clock);
      if (board.pending() != 0) begin
         $display("%0t: %0d decisions never arrived: expected %0d, actual 0",
                  $time, board.pending(), board.pending());
         board.errors++;
      end
      $display("Checked %0d requests under %0d interface settings: %0d forwards, %0d echo replies,",
               board.requests, settings_used, board.act_seen[ACT_FORWARD], board.act_seen[ACT_ECHO]);
      $display("%0d ICMP errors, %0d drops, %0d ARP handoffs, %0d appends to a full table.",
               board.act_seen[ACT_TIME_EXCEEDED] + board.act_seen[ACT_NET_UNREACH] +
               board.act_seen[ACT_PORT_UNREACH], board.act_seen[ACT_DROP],
               board.act_seen[ACT_ARP], board.full_seen);
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/ipvfd_pkg.sv
hw/rtl/ipvfd_ram.sv
hw/rtl/ipvfd_ctrl.sv
hw/rtl/ipvfd_dp.sv
hw/rtl/ipv4_forwarding_decision.sv
tb/sv/ipv4_forwarding_decision_tb.sv
